FILE: rtl/core/rrq_pkg.sv
// Shared types and constants of the round-robin ready-queue scheduler.
`timescale 1ns / 1ps

package rrq_pkg;

    localparam int TASK_W  = 5;
    localparam int TASKS   = 2 ** TASK_W;
    localparam int CNT_W   = $clog2(TASKS + 1);
    localparam int OP_W    = 3;
    localparam int PRIO_W  = 8;
    localparam int BS_W    = 2;
    localparam int ERR_W   = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_W   = PADDR_W - 2;

    localparam logic [PRIO_W-1:0] MAIN_PRIO      = PRIO_W'(31);
    localparam logic [TASK_W-1:0] IDLE_RESET     = TASK_W'(1);
    localparam logic [REG_W-1:0]  REG_IDLE_TASK  = REG_W'(0);
    localparam logic [BS_W-1:0]   BS_BLOCKED     = BS_W'(0);
    localparam logic [BS_W-1:0]   BS_WAITING     = BS_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_CREATE    = 3'd0,
        OP_TIMESLICE = 3'd1,
        OP_BLOCK     = 3'd2,
        OP_UNBLOCK   = 3'd3,
        OP_YIELD     = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_UNUSED  = 3'd0,
        ST_RUNNING = 3'd1,
        ST_READY   = 3'd2,
        ST_BLOCKED = 3'd3,
        ST_WAITING = 3'd4,
        ST_HANGING = 3'd5
    } t_status;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK            = 2'd0,
        ERR_IN_USE        = 2'd1,
        ERR_NOT_BLOCKED   = 2'd2,
        ERR_NONE_RUNNABLE = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PASS
    } t_state;

    typedef enum logic [1:0] {
        CH_HOLD,
        CH_PUSH_TAIL,
        CH_PUSH_HEAD,
        CH_POP
    } t_chain_op;

    typedef enum logic [1:0] {
        SRC_NEW,
        SRC_PREV,
        SRC_NEXT
    } t_cell_src;

    typedef struct packed {
        t_chain_op         op;
        logic [TASK_W-1:0] tid;
    } t_chain_req;

    typedef struct packed {
        logic      en;
        t_cell_src src;
    } t_cell_ctl;

endpackage

FILE: rtl/core/rrq_if.sv
// Request and response channel interfaces of the scheduler.
`timescale 1ns / 1ps

interface rrq_req_if;
    import rrq_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [TASK_W-1:0] task_req;
    logic [PRIO_W-1:0] priority_req;
    logic [BS_W-1:0]   block_status;

    modport source (
        output valid, operation, task_req, priority_req, block_status,
        input  ready
    );
    modport sink (
        input  valid, operation, task_req, priority_req, block_status,
        output ready
    );
endinterface

interface rrq_rsp_if;
    import rrq_pkg::*;

    logic              valid;
    logic              ready;
    logic [TASK_W-1:0] running_task;
    logic [PRIO_W-1:0] time_slice;
    logic              switched;
    logic [ERR_W-1:0]  error;

    modport source (
        output valid, running_task, time_slice, switched, error,
        input  ready
    );
    modport sink (
        input  valid, running_task, time_slice, switched, error,
        output ready
    );
endinterface

FILE: rtl/core/rrq_cell.sv
// One slot of the ready deque: holds a task number, loads new or neighbour data.
`timescale 1ns / 1ps

module rrq_cell (
    input  logic                      i_clk,
    input  rrq_pkg::t_cell_ctl        i_ctl,
    input  logic [rrq_pkg::TASK_W-1:0] i_new,
    input  logic [rrq_pkg::TASK_W-1:0] i_prev,
    input  logic [rrq_pkg::TASK_W-1:0] i_next,
    output logic [rrq_pkg::TASK_W-1:0] o_task
);
    import rrq_pkg::*;

    logic [TASK_W-1:0] r_task;
    logic [TASK_W-1:0] n_task;

    always_comb begin
        n_task = r_task;
        if (i_ctl.en) begin
            case (i_ctl.src)
                SRC_NEW:  n_task = i_new;
                SRC_PREV: n_task = i_prev;
                SRC_NEXT: n_task = i_next;
                default:  n_task = r_task;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_task <= n_task;
    end

    assign o_task = r_task;

endmodule

FILE: rtl/core/rrq_chain.sv
// Ready deque as a row of cells; slot 0 is the head, the fill count marks the tail.
`timescale 1ns / 1ps

module rrq_chain (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rrq_pkg::t_chain_req        i_req,
    output logic [rrq_pkg::CNT_W-1:0]  o_count,
    output logic [rrq_pkg::TASK_W-1:0] o_head
);
    import rrq_pkg::*;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              w_full;
    logic              w_empty;
    logic [TASK_W-1:0] w_task [TASKS];
    logic [TASK_W-1:0] w_prev [TASKS];
    logic [TASK_W-1:0] w_next [TASKS];
    t_cell_ctl         w_ctl  [TASKS];

    assign w_full  = (r_count == CNT_W'(TASKS));
    assign w_empty = (r_count == '0);

    // per-slot control: tail append hits one slot, head push and pop shift the row
    always_comb begin
        for (int k = 0; k < TASKS; k++) begin
            w_ctl[k] = '{en: 1'b0, src: SRC_NEW};
            case (i_req.op)
                CH_PUSH_TAIL: w_ctl[k] = '{en: !w_full && (r_count == CNT_W'(k)),
                                           src: SRC_NEW};
                CH_PUSH_HEAD: w_ctl[k] = '{en: !w_full,
                                           src: (k == 0) ? SRC_NEW : SRC_PREV};
                CH_POP:       w_ctl[k] = '{en: !w_empty, src: SRC_NEXT};
                default:      w_ctl[k] = '{en: 1'b0, src: SRC_NEW};
            endcase
        end
    end

    for (genvar g = 0; g < TASKS; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_prev[g] = i_req.tid;
        end else begin : g_mid
            assign w_prev[g] = w_task[g-1];
        end
        if (g == TASKS - 1) begin : g_last
            assign w_next[g] = w_task[g];
        end else begin : g_inner
            assign w_next[g] = w_task[g+1];
        end

        rrq_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl[g]),
            .i_new  (i_req.tid),
            .i_prev (w_prev[g]),
            .i_next (w_next[g]),
            .o_task (w_task[g])
        );
    end

    always_comb begin
        n_count = r_count;
        case (i_req.op)
            CH_PUSH_TAIL,
            CH_PUSH_HEAD: if (!w_full)  n_count = r_count + CNT_W'(1);
            CH_POP:       if (!w_empty) n_count = r_count - CNT_W'(1);
            default:      n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;
    assign o_head  = w_task[0];

endmodule

FILE: rtl/core/round_robin_ready_queue.sv
// Top level of the round-robin ready-queue task scheduler.
`timescale 1ns / 1ps

// Usage
//   i_req  : one scheduler operation per transfer (create, timeslice expired,
//            block current, unblock task, yield) with task, priority and
//            block status.
//   o_rsp  : exactly one transfer per request: running task, its slice
//            (priority), switched flag and error code.
//   APB    : one register, idle_task at byte address 0, read back as is; pready
//            tied high. The user writes only while the block is idle (unenforced).
// Sequence
//   Create, unblock and unknown codes go from the accept state to a step on
//   the task table; the response is registered and valid in the cycle after
//   that step. Timeslice, block and yield add a scheduling pass after the
//   table step. A new request is taken only back in the idle state. The task
//   status table sees one read and one write per cycle.
// Reset
//   Task 0 running with priority 31, all other tasks unused, deque empty,
//   idle task 1. No clearing pass; the block accepts at once.
// Back-pressure
//   A request may be taken while a response waits; its final step holds
//   until the output register is free.
module round_robin_ready_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    rrq_req_if.sink                      i_req,
    rrq_rsp_if.source                    o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rrq_pkg::PADDR_W-1:0]  paddr,
    input  logic [rrq_pkg::PDATA_W-1:0]  pwdata,
    output logic [rrq_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import rrq_pkg::*;

    function automatic logic is_stopped(input t_status s);
        return (s == ST_BLOCKED) || (s == ST_WAITING) || (s == ST_HANGING);
    endfunction

    // control and latched request
    t_state            r_state;
    t_state            n_state;
    logic [OP_W-1:0]   r_op;
    logic [TASK_W-1:0] r_tid;
    logic [PRIO_W-1:0] r_prio_req;
    logic [BS_W-1:0]   r_bs;
    logic [TASK_W-1:0] r_cur;
    logic [TASK_W-1:0] n_cur;
    logic [TASK_W-1:0] r_idle;

    // task table: one entry per task, reset values held in flops
    t_status           r_status [TASKS];
    logic [PRIO_W-1:0] r_prio   [TASKS];
    logic [TASK_W-1:0] w_st_ra;
    t_status           w_st_rd;
    logic              w_st_we;
    logic [TASK_W-1:0] w_st_wa;
    t_status           w_st_wd;
    logic              w_pr_we;
    logic [TASK_W-1:0] w_pr_ra;

    // deque
    t_chain_req        w_chain;
    logic [CNT_W-1:0]  w_count;
    logic [TASK_W-1:0] w_head;

    // response register
    logic              r_out_valid;
    logic [TASK_W-1:0] r_out_task;
    logic [PRIO_W-1:0] r_out_slice;
    logic              r_out_sw;
    t_err              r_out_err;
    logic              w_out_load;
    logic [TASK_W-1:0] w_out_task;
    logic              w_out_sw;
    t_err              w_out_err;

    logic              w_in_acc;
    logic              w_fin_ok;
    logic              w_pass_ok;
    logic              w_cfg_wr;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_in_acc    = i_req.valid && i_req.ready;
    // last step of a request may only go ahead when the response slot frees up
    assign w_fin_ok    = !r_out_valid || o_rsp.ready;

    assign w_st_rd = r_status[w_st_ra];

    rrq_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_chain),
        .o_count (w_count),
        .o_head  (w_head)
    );

    // next state and table/deque commands
    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        w_st_ra    = r_cur;
        w_st_we    = 1'b0;
        w_st_wa    = r_cur;
        w_st_wd    = ST_READY;
        w_pr_we    = 1'b0;
        w_pr_ra    = r_cur;
        w_chain    = '{op: CH_HOLD, tid: r_cur};
        w_out_load = 1'b0;
        w_out_task = r_cur;
        w_out_sw   = 1'b0;
        w_out_err  = ERR_OK;
        w_pass_ok  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                case (r_op)
                    OP_CREATE: begin
                        w_st_ra = r_tid;
                        if (w_fin_ok) begin
                            w_out_load = 1'b1;
                            n_state    = S_IDLE;
                            if (w_st_rd != ST_UNUSED) begin
                                w_out_err = ERR_IN_USE;
                            end else begin
                                w_st_we = 1'b1;
                                w_st_wa = r_tid;
                                w_st_wd = ST_READY;
                                w_pr_we = 1'b1;
                                w_chain = '{op: CH_PUSH_TAIL, tid: r_tid};
                            end
                        end
                    end
                    OP_UNBLOCK: begin
                        w_st_ra = r_tid;
                        if (w_fin_ok) begin
                            w_out_load = 1'b1;
                            n_state    = S_IDLE;
                            if (is_stopped(w_st_rd)) begin
                                w_st_we = 1'b1;
                                w_st_wa = r_tid;
                                w_st_wd = ST_READY;
                                w_chain = '{op: CH_PUSH_HEAD, tid: r_tid};
                            end else begin
                                w_out_err = ERR_NOT_BLOCKED;
                            end
                        end
                    end
                    OP_TIMESLICE,
                    OP_YIELD: begin
                        // requeue the running task before the pass
                        if (w_st_rd == ST_RUNNING) begin
                            w_st_we = 1'b1;
                            w_st_wd = ST_READY;
                            w_chain = '{op: CH_PUSH_TAIL, tid: r_cur};
                        end
                        n_state = S_PASS;
                    end
                    OP_BLOCK: begin
                        if (w_st_rd == ST_RUNNING) begin
                            w_st_we = 1'b1;
                            if (r_bs == BS_BLOCKED) begin
                                w_st_wd = ST_BLOCKED;
                            end else if (r_bs == BS_WAITING) begin
                                w_st_wd = ST_WAITING;
                            end else begin
                                w_st_wd = ST_HANGING;
                            end
                        end
                        n_state = S_PASS;
                    end
                    default: begin
                        if (w_fin_ok) begin
                            w_out_load = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end
                endcase
            end

            S_PASS: begin
                // empty deque: waking the idle task and popping it at once
                // leaves the deque as it was, so it runs directly
                w_st_ra = r_idle;
                if (w_count != '0) begin
                    w_pass_ok = 1'b1;
                    w_st_wa   = w_head;
                end else if (is_stopped(w_st_rd)) begin
                    w_pass_ok = 1'b1;
                    w_st_wa   = r_idle;
                end
                if (w_fin_ok) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                    if (w_pass_ok) begin
                        w_st_we    = 1'b1;
                        w_st_wd    = ST_RUNNING;
                        n_cur      = w_st_wa;
                        w_out_task = w_st_wa;
                        w_pr_ra    = w_st_wa;
                        w_out_sw   = 1'b1;
                        if (w_count != '0) begin
                            w_chain = '{op: CH_POP, tid: r_cur};
                        end
                    end else begin
                        w_out_err = ERR_NONE_RUNNABLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= '0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op       <= i_req.operation;
            r_tid      <= i_req.task_req;
            r_prio_req <= i_req.priority_req;
            r_bs       <= i_req.block_status;
        end
    end

    for (genvar g = 0; g < TASKS; g++) begin : g_entry
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_status[g] <= (g == 0) ? ST_RUNNING : ST_UNUSED;
                r_prio[g]   <= (g == 0) ? MAIN_PRIO : '0;
            end else begin
                if (w_st_we && (w_st_wa == TASK_W'(g))) begin
                    r_status[g] <= w_st_wd;
                end
                if (w_pr_we && (r_tid == TASK_W'(g))) begin
                    r_prio[g] <= r_prio_req;
                end
            end
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_task  <= w_out_task;
            r_out_slice <= r_prio[w_pr_ra];
            r_out_sw    <= w_out_sw;
            r_out_err   <= w_out_err;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.running_task = r_out_task;
    assign o_rsp.time_slice   = r_out_slice;
    assign o_rsp.switched     = r_out_sw;
    assign o_rsp.error        = r_out_err;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle <= IDLE_RESET;
        end else if (w_cfg_wr && (paddr[PADDR_W-1:2] == REG_IDLE_TASK)) begin
            r_idle <= pwdata[TASK_W-1:0];
        end
    end

    assign prdata = (paddr[PADDR_W-1:2] == REG_IDLE_TASK)
                  ? {{(PDATA_W-TASK_W){1'b0}}, r_idle} : '0;

    // checks
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_EXEC))
        else $error("accepted request did not start execution");

    a_current_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_status[r_cur] != ST_UNUSED)
        else $error("current task has unused status");

    a_switch_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sw) |-> (r_out_err == ERR_OK))
        else $error("switch reported together with an error");

    a_pass_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS && w_fin_ok && w_pass_ok)
        |=> (r_status[r_cur] == ST_RUNNING && r_out_task == r_cur))
        else $error("selected task not running after pass");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CNT_W'(TASKS))
        else $error("deque count beyond capacity");

endmodule
